// ===== design/fdmd_pkg.sv =====
package fdmd_pkg;

  // Frame geometry fixed at build time.
  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;

  // Frame store address and pixel index widths. The index can also hold PIX_COUNT itself.
  localparam int unsigned ADDR_W = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam int unsigned IDX_W  = $clog2(PIX_COUNT + 1);

  // Field widths of the channels.
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned COUNT_W = 19;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned PROD_W  = COUNT_W + RATIO_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes, at byte address 4*index.
  typedef enum logic [1:0] {
    REG_DIFF_THRESHOLD = 2'd0,
    REG_RATIO_DIVISOR  = 2'd1,
    REG_HOLD_TIME      = 2'd2,
    REG_STILL_MODE     = 2'd3
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic [PIXEL_W-1:0] DIFF_THRESHOLD_RST = 8'd120;
  localparam logic [RATIO_W-1:0] RATIO_DIVISOR_RST  = 16'd5000;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_RST      = 16'd200;

endpackage

// ===== design/fdmd_if.sv =====
// Pixel channel: one item is one gray pixel with its frame marks.
interface fdmd_pixel_if;
  import fdmd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               last_pixel;
  logic [TIME_W-1:0]  frame_time;

  modport source (output valid, output pixel, output last_pixel, output frame_time,
                  input ready);
  modport sink   (input valid, input pixel, input last_pixel, input frame_time,
                  output ready);
endinterface

// Result channel: one item per frame.
interface fdmd_result_if;
  import fdmd_pkg::*;

  logic               valid;
  logic               ready;
  logic               moving;
  logic [COUNT_W-1:0] changed_count;

  modport source (output valid, output moving, output changed_count, input ready);
  modport sink   (input valid, input moving, input changed_count, output ready);
endinterface

// ===== design/frame_difference_motion_detector_top.sv =====
// Frame difference motion detector.
// Pixels enter on the pix channel (valid/ready) in raster order, one per clock
// at full rate while pix.ready is high; last_pixel marks the final pixel of a
// frame. One item leaves on the res channel per frame: moving and changed_count.
// Each pixel reads the previous frame's sample at the same position from a
// single-port frame store and writes the new sample in the same cycle
// (read-first), so no two accesses to one entry ever overlap.
// Throughput: one pixel per cycle while pix.ready is high, set by the single frame
// store port. After the last pixel is accepted, the store read and count come
// first, then the ratio test, and the result is then held in the output register.
// When the receiver stalls, one result waits in the output register and pixels
// keep flowing; pix.ready falls only when a second finished frame reaches the
// last stage while the first result is still waiting.
// Reset (synchronous, rst high) loads the register defaults, clears the pixel
// index, change counter, movement stamp and the previous-frame flag, so the
// first frame after reset reports moving with a count of zero. The frame store
// itself is not cleared. Registers are written over the APB port at 4*index.
module frame_difference_motion_detector_top (
  input  logic                          clk,
  input  logic                          rst,
  fdmd_pixel_if.sink                    pix,
  fdmd_result_if.source                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [fdmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [fdmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fdmd_pkg::*;

  // Configuration registers.
  logic [PIXEL_W-1:0] diff_threshold;
  logic [RATIO_W-1:0] ratio_divisor;
  logic [HOLD_W-1:0]  hold_time;
  logic               still_mode;

  reg_idx_t reg_sel;
  logic     cfg_wr;

  // Frame store.
  logic [PIXEL_W-1:0] frame_mem [PIX_COUNT];
  logic [PIXEL_W-1:0] frame_rd;

  // Input stage.
  logic [IDX_W-1:0]   pix_idx;
  logic [IDX_W-1:0]   pix_idx_next;
  logic               accept;
  logic               in_range;
  logic [ADDR_W-1:0]  wr_addr;

  // Compare stage.
  logic               s1_valid;
  logic               s1_last;
  logic               s1_in_range;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [TIME_W-1:0]  s1_time;
  logic [PIXEL_W-1:0] pix_diff;
  logic               changed;
  logic [COUNT_W-1:0] count_now;
  logic [COUNT_W-1:0] change_counter;
  logic               has_prev;

  // Decision stage.
  logic               s2_valid;
  logic               s2_last;
  logic               s2_has_prev;
  logic [COUNT_W-1:0] s2_count;
  logic [TIME_W-1:0]  s2_time;
  logic [PROD_W-1:0]  ratio_prod;
  logic               ratio_hit;
  logic [TIME_W-1:0]  elapsed;
  logic               hold_hit;
  logic               moving_now;
  logic               stamp_load;
  logic [TIME_W-1:0]  last_move_stamp;

  // Output register.
  logic               res_valid;
  logic               res_moving;
  logic [COUNT_W-1:0] res_count;

  logic               advance;

  // The pipe only stops when a finished frame cannot enter the busy output register.
  assign advance = !(s2_valid && s2_last && res_valid && !res.ready);

  // Configuration port decode.
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DIFF_THRESHOLD: prdata = PDATA_W'(diff_threshold);
      REG_RATIO_DIVISOR:  prdata = PDATA_W'(ratio_divisor);
      REG_HOLD_TIME:      prdata = PDATA_W'(hold_time);
      REG_STILL_MODE:     prdata = PDATA_W'(still_mode);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= DIFF_THRESHOLD_RST;
      ratio_divisor  <= RATIO_DIVISOR_RST;
      hold_time      <= HOLD_TIME_RST;
      still_mode     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DIFF_THRESHOLD: diff_threshold <= pwdata[PIXEL_W-1:0];
        REG_RATIO_DIVISOR:  ratio_divisor  <= pwdata[RATIO_W-1:0];
        REG_HOLD_TIME:      hold_time      <= pwdata[HOLD_W-1:0];
        REG_STILL_MODE:     still_mode     <= pwdata[0];
      endcase
    end
  end

  // Input stage: pixel index and store access.
  assign pix.ready = advance;
  assign accept    = pix.valid && advance;
  assign in_range  = pix_idx < IDX_W'(PIX_COUNT);
  assign wr_addr   = pix_idx[ADDR_W-1:0];

  always_comb begin
    pix_idx_next = pix_idx;
    if (pix.last_pixel) begin
      pix_idx_next = '0;
    end else if (in_range) begin
      pix_idx_next = pix_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_idx <= '0;
    end else if (accept) begin
      pix_idx <= pix_idx_next;
    end
  end

  // Read-first store: the old sample comes out while the new one goes in.
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      frame_rd           <= frame_mem[wr_addr];
      frame_mem[wr_addr] <= pix.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last     <= pix.last_pixel;
      s1_in_range <= in_range;
      s1_pixel    <= pix.pixel;
      s1_time     <= pix.frame_time;
    end
  end

  // Compare stage: absolute difference against the threshold, saturating count.
  assign pix_diff  = (s1_pixel > frame_rd) ? (s1_pixel - frame_rd) : (frame_rd - s1_pixel);
  assign changed   = s1_in_range && has_prev && (pix_diff > diff_threshold)
                     && (change_counter != COUNT_MAX);
  assign count_now = change_counter + COUNT_W'(changed);

  always_ff @(posedge clk) begin
    if (rst) begin
      change_counter <= '0;
      has_prev       <= 1'b0;
    end else if (advance && s1_valid) begin
      change_counter <= s1_last ? '0 : count_now;
      if (s1_last) begin
        has_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_last     <= s1_last;
      s2_has_prev <= has_prev;
      s2_count    <= count_now;
      s2_time     <= s1_time;
    end
  end

  // Decision stage: ratio test, hold window and mode overrides.
  assign ratio_prod = PROD_W'(s2_count) * PROD_W'(ratio_divisor);
  assign ratio_hit  = ratio_prod > PROD_W'(PIX_COUNT);
  assign elapsed    = s2_time - last_move_stamp;
  assign hold_hit   = elapsed < TIME_W'(hold_time);

  always_comb begin
    moving_now = 1'b0;
    stamp_load = 1'b0;
    if (still_mode) begin
      moving_now = 1'b0;
    end else if (!s2_has_prev) begin
      moving_now = 1'b1;
    end else if (ratio_hit) begin
      moving_now = 1'b1;
      stamp_load = 1'b1;
    end else begin
      moving_now = hold_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_move_stamp <= '0;
    end else if (advance && s2_valid && s2_last && stamp_load) begin
      last_move_stamp <= s2_time;
    end
  end

  // Output register: holds one result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s2_valid && s2_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid && s2_last) begin
      res_moving <= moving_now;
      res_count  <= s2_count;
    end
  end

  assign res.valid         = res_valid;
  assign res.moving        = res_moving;
  assign res.changed_count = res_count;

`ifndef ASSERT_OFF
  // A stalled compare stage keeps its pixel and its store sample.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(frame_rd) && $stable(s1_pixel))
    else $error("compare stage lost its item during a stall");

  // The pixel index never runs more than one past the last entry of the frame store.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    pix_idx <= IDX_W'(PIX_COUNT))
    else $error("pixel index beyond frame size");

  // A new result only ever comes from a last pixel in the decision stage.
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s2_valid && s2_last))
    else $error("result raised without a finished frame");
`endif

endmodule

// ===== bench/fdmd_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the motion detector,
// keeps its own copy of the frame store and registers, predicts one verdict
// per frame and compares every accepted result item with the oldest one due.
module fdmd_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  fdmd_pixel_if                         pix,
  fdmd_result_if                        res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [fdmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [fdmd_pkg::PDATA_W-1:0]  pwdata,
  output int                            mismatches,
  output int                            awaiting
);
  import fdmd_pkg::*;

  typedef struct packed {
    logic               moving;
    logic [COUNT_W-1:0] changed_count;
  } frame_verdict_t;

  // Verdicts of finished frames that have not yet left the block.
  frame_verdict_t verdicts_due[$];

  // Shadow of the frame store and of the per-frame state.
  logic [PIXEL_W-1:0] shadow_frame [PIX_COUNT];
  logic               have_prior;
  logic [IDX_W-1:0]   frame_pos;
  logic [COUNT_W-1:0] changed_so_far;
  logic [TIME_W-1:0]  move_stamp;

  // Shadow of the configuration registers.
  logic [PIXEL_W-1:0] threshold;
  logic [RATIO_W-1:0] divisor;
  logic [HOLD_W-1:0]  hold_span;
  logic               still_mode;

  // Working values of the current clock edge.
  logic [PIXEL_W-1:0] prior_px;
  logic [PIXEL_W-1:0] px_gap;
  logic [TIME_W-1:0]  elapsed;
  logic [63:0]        weight;
  frame_verdict_t     verdict;
  frame_verdict_t     oldest_due;

  always @(posedge clk) begin
    if (rst) begin
      verdicts_due.delete();
      have_prior     = 1'b0;
      frame_pos      = '0;
      changed_so_far = '0;
      move_stamp     = '0;
      threshold      = DIFF_THRESHOLD_RST;
      divisor        = RATIO_DIVISOR_RST;
      hold_span      = HOLD_TIME_RST;
      still_mode     = 1'b0;
      mismatches     = 0;
    end else begin
      // Register writes complete in the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_DIFF_THRESHOLD: threshold  = pwdata[PIXEL_W-1:0];
          REG_RATIO_DIVISOR:  divisor    = pwdata[RATIO_W-1:0];
          REG_HOLD_TIME:      hold_span  = pwdata[HOLD_W-1:0];
          REG_STILL_MODE:     still_mode = pwdata[0];
          default: ;
        endcase
      end

      // A pixel item: compare with the stored one, then overwrite it.
      // Pixels past the end of the frame store are dropped.
      if (pix.valid && pix.ready) begin
        if (frame_pos < PIX_COUNT) begin
          if (have_prior) begin
            prior_px = shadow_frame[frame_pos];
            px_gap = (pix.pixel > prior_px) ? pix.pixel - prior_px : prior_px - pix.pixel;
            if (px_gap > threshold && changed_so_far != COUNT_MAX)
              changed_so_far = changed_so_far + 1'b1;
          end
          shadow_frame[frame_pos] = pix.pixel;
          frame_pos = frame_pos + 1'b1;
        end

        // End of frame: judge it. Only a passing ratio test moves the stamp.
        if (pix.last_pixel) begin
          verdict.changed_count = changed_so_far;
          weight  = 64'(changed_so_far) * 64'(divisor);
          elapsed = pix.frame_time - move_stamp;
          if (still_mode) begin
            verdict.moving = 1'b0;
          end else if (!have_prior) begin
            verdict.moving = 1'b1;
          end else if (weight > 64'(PIX_COUNT)) begin
            verdict.moving = 1'b1;
            move_stamp = pix.frame_time;
          end else begin
            verdict.moving = (elapsed < TIME_W'(hold_span));
          end
          verdicts_due.push_back(verdict);
          have_prior     = 1'b1;
          frame_pos      = '0;
          changed_so_far = '0;
        end
      end

      // A result item: it must match the oldest verdict due.
      if (res.valid && res.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result item with no frame finished: moving %0d, changed_count %0d",
                 res.moving, res.changed_count);
          mismatches++;
        end else begin
          oldest_due = verdicts_due.pop_front();
          if (res.moving !== oldest_due.moving) begin
            $error("moving: expected %0d, actual %0d", oldest_due.moving, res.moving);
            mismatches++;
          end
          if (res.changed_count !== oldest_due.changed_count) begin
            $error("changed_count: expected %0d, actual %0d",
                   oldest_due.changed_count, res.changed_count);
            mismatches++;
          end
        end
      end
    end
    awaiting = verdicts_due.size();
  end

endmodule

// ===== bench/frame_difference_motion_detector_top_test.sv =====
`timescale 1ns / 1ps

module frame_difference_motion_detector_top_test;
  import fdmd_pkg::*;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_FLAT,
    FILL_BLACK,
    FILL_WHITE
  } frame_fill_t;

  // Movement stamp set just below the point where frame time wraps.
  localparam logic [TIME_W-1:0] TOP_STAMP = 31'h7FFF_FFF6;

  // Longest frame of the run; the first frame writes this much of the store.
  localparam int unsigned PRIME_LEN = 64;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fdmd_pixel_if  pix ();
  fdmd_result_if res ();

  int                  mismatches;
  int                  awaiting;
  int                  pixels_sent;
  int                  frames_sent;
  int                  base_pixels;
  bit                  sender_gaps;
  bit                  receiver_gaps;
  bit                  long_hold;
  bit                  long_hold_done;
  logic [TIME_W-1:0]   wall_clock;

  frame_difference_motion_detector_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fdmd_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    long_hold_done = 1'b0;
    forever begin
      if (long_hold && !long_hold_done) begin
        res.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // One register write: setup cycle, access cycle, then idle with psel low. Bits
  // above the register's width carry random junk.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value,
                           input int unsigned field_w);
    logic [31:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (junk << field_w) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering pixels, wait until every finished frame has been
  // reported, then let the pipeline run empty.
  task automatic drain_results();
    pix.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);
  endtask

  // Offer one pixel item and hold it until it is accepted.
  task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic last,
                            input logic [TIME_W-1:0] stamp);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.pixel      <= value;
    pix.last_pixel <= last;
    pix.frame_time <= stamp;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
  endtask

  // One frame of len pixels. Now and then the time stamp on the pixels
  // before the last one is scrambled; only the last one counts. The pixel
  // stays offered afterwards until the next frame or a drain.
  task automatic send_frame(input int unsigned len, input frame_fill_t fill,
                            input logic [TIME_W-1:0] stamp);
    logic [PIXEL_W-1:0] flat;
    logic [PIXEL_W-1:0] value;
    logic [TIME_W-1:0]  t;
    bit                 scatter;
    flat    = $urandom_range(0, 255);
    scatter = ($urandom_range(0, 9) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      case (fill)
        FILL_RANDOM: value = $urandom_range(0, 255);
        FILL_FLAT:   value = flat;
        FILL_BLACK:  value = '0;
        default:     value = '1;
      endcase
      // Pixels past the frame store must be dropped, so make them visible.
      if (k >= PIX_COUNT)
        value = $urandom_range(1, 255);
      t = (scatter && k + 1 < len) ? TIME_W'($urandom()) : stamp;
      send_pixel(value, k + 1 == len, t);
    end
    frames_sent++;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [31:0]  pick;
    int unsigned  frames_here;
    int unsigned  len;
    frame_fill_t  fill;
    int           phase;

    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pix.valid      <= 1'b0;
    pix.pixel      <= '0;
    pix.last_pixel <= 1'b0;
    pix.frame_time <= '0;
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    long_hold     = 1'b0;
    pixels_sent   = 0;
    frames_sent   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_DIFF_THRESHOLD, 120, PIXEL_W);
    write_reg(REG_RATIO_DIVISOR, 5000, RATIO_W);
    write_reg(REG_HOLD_TIME, 200, HOLD_W);
    write_reg(REG_STILL_MODE, 0, 1);

    // First frame covers every store entry later frames use: moving with no count.
    send_frame(PRIME_LEN, FILL_BLACK, 31'd1000);
    drain_results();

    // Every pixel changes.
    write_reg(REG_DIFF_THRESHOLD, 254, PIXEL_W);
    send_frame(PRIME_LEN, FILL_WHITE, 31'd2000);
    drain_results();

    // Single-pixel frame, one change, no hold time.
    write_reg(REG_DIFF_THRESHOLD, 0, PIXEL_W);
    write_reg(REG_RATIO_DIVISOR, 65535, RATIO_W);
    write_reg(REG_HOLD_TIME, 0, HOLD_W);
    send_frame(1, FILL_BLACK, 31'd2001);
    drain_results();

    // Still mode still counts but never reports movement.
    write_reg(REG_STILL_MODE, 1, 1);
    send_frame(8, FILL_BLACK, 31'd2002);
    drain_results();

    // Movement detected just below the wrap of the frame time.
    write_reg(REG_STILL_MODE, 0, 1);
    send_frame(8, FILL_WHITE, TOP_STAMP);
    drain_results();

    // Hold time across the wrap; a zero divisor never passes the ratio test.
    write_reg(REG_RATIO_DIVISOR, 0, RATIO_W);
    write_reg(REG_HOLD_TIME, 100, HOLD_W);
    send_frame(2, FILL_WHITE, 31'd50);
    send_frame(2, FILL_WHITE, 31'd95);
    drain_results();

    // Longest hold time, one unit inside and exactly at its end.
    write_reg(REG_HOLD_TIME, 65535, HOLD_W);
    send_frame(2, FILL_BLACK, TOP_STAMP + TIME_W'(65534));
    send_frame(2, FILL_BLACK, TOP_STAMP + TIME_W'(65535));
    drain_results();

    // Random phases, each under a fresh mix of register settings.
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    wall_clock    = 31'd5000;
    base_pixels   = pixels_sent;
    phase         = 0;
    while (pixels_sent - base_pixels < 400) begin
      drain_results();
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 3);
        write_reg(REG_DIFF_THRESHOLD,
                  (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255), PIXEL_W);
      end
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 4);
        write_reg(REG_RATIO_DIVISOR,
                  (pick == 0) ? 1 : (pick == 1) ? 65535 : (pick == 2) ? 5000 :
                  $urandom_range(1, 65535), RATIO_W);
      end
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 3);
        write_reg(REG_HOLD_TIME,
                  (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 1000), HOLD_W);
      end
      if ($urandom_range(0, 1))
        write_reg(REG_STILL_MODE, ($urandom_range(0, 4) == 0) ? 1 : 0, 1);

      // Early on the receiver holds off long enough for the input to stall.
      if (phase == 1)
        long_hold = 1'b1;

      // The last stretch runs without gaps on either side.
      if (pixels_sent - base_pixels >= 320) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end

      frames_here = $urandom_range(3, 8);
      repeat (frames_here) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, PRIME_LEN) :
                                            $urandom_range(1, 24);
        pick = $urandom_range(0, 5);
        fill = (pick > 3) ? FILL_RANDOM : frame_fill_t'(pick[1:0]);
        pick = $urandom_range(0, 19);
        if (pick == 0)
          wall_clock = TIME_W'($urandom());
        else if (pick == 1)
          wall_clock = 31'h7FFF_FFFF - TIME_W'($urandom_range(0, 200));
        else
          wall_clock = wall_clock + TIME_W'($urandom_range(0, 400));
        send_frame(len, fill, wall_clock);
      end
      phase++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fdmd_pkg.sv
design/fdmd_if.sv
design/frame_difference_motion_detector_top.sv
bench/fdmd_result_checker.sv
bench/frame_difference_motion_detector_top_test.sv
